// ===== rtl/bblur_pkg.sv =====
// Shared constants, types and register codes for the 5x5 RGB box blur.
// Used by every module under rtl/ except bblur_ram; depends on nothing.
package bblur_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int CH_BITS    = 8;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
  localparam int PIX_BITS   = 3 * CH_BITS;

  // window geometry
  localparam int WIN        = 5;
  localparam int WIN_LO     = 2;
  localparam int WIN_AREA   = WIN * WIN;
  localparam int LINE_CELLS = WIN - 1;

  // per-channel sums: one column (5 pixels) and the full window (25 pixels)
  localparam int VSUM_BITS = $clog2(WIN * ((1 << CH_BITS) - 1) + 1);
  localparam int HSUM_BITS = $clog2(WIN_AREA * ((1 << CH_BITS) - 1) + 1);

  // divide by 25 as multiply by rounded-up reciprocal and shift
  localparam int DIV_SHIFT     = 17;
  localparam int DIV_MULT      = ((1 << DIV_SHIFT) + WIN_AREA - 1) / WIN_AREA;
  localparam int DIV_MULT_BITS = $clog2(DIV_MULT + 1);
  localparam int PROD_BITS     = HSUM_BITS + DIV_MULT_BITS;

  // configuration port
  localparam int WCFG_BITS     = COL_BITS + 1;
  localparam int HCFG_BITS     = ROW_BITS + 1;
  localparam int CFG_DATA_BITS = HCFG_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int WIDTH_RESET   = 1024;
  localparam int HEIGHT_RESET  = 1024;

  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // stream widths
  localparam int IN_DATA_BITS   = ((PIX_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = PIX_BITS + ROW_BITS + COL_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef logic [CH_BITS-1:0]   chan_t;
  typedef logic [VSUM_BITS-1:0] vsum_t;
  typedef logic [HSUM_BITS-1:0] hsum_t;
  typedef logic [1:0]           sel_t;

  // red in the low bits
  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  typedef struct packed {
    vsum_t blue;
    vsum_t green;
    vsum_t red;
  } vsum_rgb_t;

  typedef struct packed {
    hsum_t blue;
    hsum_t green;
    hsum_t red;
  } hsum_rgb_t;

  // Per-pixel control that rides along the chain.
  // j selects center row r-2+j, i selects center column c-2+i.
  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last_row;
    logic                last_col;
    logic                has_out;
    sel_t                j_first;
    sel_t                j_last;
    sel_t                i_first;
    sel_t                i_last;
    logic [WIN-1:0]      rmask;   // bit k: row r-k is inside the frame
    logic [WIN-1:0]      cmask;   // bit k: column c-k is inside the row
  } item_meta_t;

  typedef struct packed {
    item_meta_t meta;
    pixel_t     pix;       // pixel of the row this cell sees
    vsum_rgb_t  acc;       // column sum of the rows seen so far
    vsum_rgb_t  acc_prev;  // column sum one row shorter
  } cell_bus_t;

  // column sums for centers two, one and zero rows above the input row
  typedef struct packed {
    vsum_rgb_t v3;
    vsum_rgb_t v4;
    vsum_rgb_t v5;
  } vcol_t;

  typedef struct packed {
    hsum_rgb_t           sum;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                run_last;
    logic                frame_last;
  } res_t;

  typedef struct packed {
    logic                run_last;
    logic                frame_last;
    logic [COL_BITS-1:0] col;
    logic [ROW_BITS-1:0] row;
    pixel_t              rgb;
  } out_beat_t;

endpackage

// ===== rtl/bblur_ram.sv =====
// Generic single-clock RAM: one write port, one registered read port.
// Read-first on a same-address write. No dependencies.
module bblur_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bblur_line_cell.sv =====
// One line-delay cell: stores a row of pixels and adds its row to the column sum.
// Depends on bblur_pkg and bblur_ram.
module bblur_line_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  bblur_pkg::cell_bus_t in_bus,
  output logic                 out_valid,
  output bblur_pkg::cell_bus_t out_bus
);
  import bblur_pkg::*;

  pixel_t     old_pix;
  pixel_t     add_pix;
  vsum_rgb_t  acc_next;
  item_meta_t meta_next;
  item_meta_t meta;
  vsum_rgb_t  acc;
  vsum_rgb_t  acc_prev;

  // write this row's pixel, read back the row above at the same column
  bblur_ram #(
    .WIDTH(PIX_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (en && in_valid),
    .waddr (in_bus.meta.col),
    .wdata (in_bus.pix),
    .re    (en),
    .raddr (in_bus.meta.col),
    .rdata (old_pix)
  );

  always_comb begin
    add_pix        = in_bus.meta.rmask[0] ? in_bus.pix : '0;
    acc_next.red   = in_bus.acc.red   + VSUM_BITS'(add_pix.red);
    acc_next.green = in_bus.acc.green + VSUM_BITS'(add_pix.green);
    acc_next.blue  = in_bus.acc.blue  + VSUM_BITS'(add_pix.blue);
    meta_next       = in_bus.meta;
    meta_next.rmask = in_bus.meta.rmask >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta     <= meta_next;
      acc      <= acc_next;
      acc_prev <= in_bus.acc;
    end
  end

  always_comb begin
    out_bus.meta     = meta;
    out_bus.pix      = old_pix;
    out_bus.acc      = acc;
    out_bus.acc_prev = acc_prev;
  end

endmodule

// ===== rtl/bblur_window.sv =====
// Horizontal window: five column-sum taps and the burst sequencer that
// walks the centers finished by one pixel. Depends on bblur_pkg.
module bblur_window (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  bblur_pkg::cell_bus_t in_bus,
  output logic                 take,
  output logic                 res_valid,
  output bblur_pkg::res_t      res
);
  import bblur_pkg::*;

  vcol_t      taps [WIN];
  vcol_t      col_new;
  logic       bvalid;
  item_meta_t meta;
  sel_t       jcur;
  sel_t       icur;
  logic       at_last;
  logic       bdone;
  vsum_rgb_t  pick;
  hsum_rgb_t  sum;

  // column sums of the incoming column; the 5-row one adds the oldest row
  always_comb begin
    col_new.v3 = in_bus.acc_prev;
    col_new.v4 = in_bus.acc;
    col_new.v5 = in_bus.acc;
    if (in_bus.meta.rmask[0]) begin
      col_new.v5.red   = in_bus.acc.red   + VSUM_BITS'(in_bus.pix.red);
      col_new.v5.green = in_bus.acc.green + VSUM_BITS'(in_bus.pix.green);
      col_new.v5.blue  = in_bus.acc.blue  + VSUM_BITS'(in_bus.pix.blue);
    end
  end

  assign at_last = (jcur == meta.j_last) && (icur == meta.i_last);
  assign bdone   = !meta.has_out || at_last;
  assign take    = adv && (!bvalid || bdone);

  // window sum for the current (j, i): taps c-k with k <= 4-i inside the row
  always_comb begin
    sum  = '0;
    pick = '0;
    for (int k = 0; k < WIN; k++) begin
      case (jcur)
        2'd0:    pick = taps[k].v5;
        2'd1:    pick = taps[k].v4;
        default: pick = taps[k].v3;
      endcase
      if (meta.cmask[k] && ((k + int'(icur)) < WIN)) begin
        sum.red   = sum.red   + HSUM_BITS'(pick.red);
        sum.green = sum.green + HSUM_BITS'(pick.green);
        sum.blue  = sum.blue  + HSUM_BITS'(pick.blue);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        bvalid <= in_valid;
      end
      if (adv) begin
        res_valid <= bvalid && meta.has_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      taps[0] <= col_new;
      for (int k = 1; k < WIN; k++) begin
        taps[k] <= taps[k-1];
      end
      meta <= in_bus.meta;
      jcur <= in_bus.meta.j_first;
      icur <= in_bus.meta.i_first;
    end else if (adv && bvalid && !bdone) begin
      if (icur == meta.i_last) begin
        icur <= meta.i_first;
        jcur <= jcur + 2'd1;
      end else begin
        icur <= icur + 2'd1;
      end
    end
    if (adv) begin
      res.sum        <= sum;
      res.row        <= meta.row + ROW_BITS'(jcur) - ROW_BITS'(WIN_LO);
      res.col        <= meta.col + COL_BITS'(icur) - COL_BITS'(WIN_LO);
      res.run_last   <= at_last;
      res.frame_last <= meta.last_row && meta.last_col &&
                        (jcur == sel_t'(WIN_LO)) && (icur == sel_t'(WIN_LO));
    end
  end

  a_icur_range: assert property (@(posedge clk) disable iff (rst)
    (bvalid && meta.has_out) |-> (icur >= meta.i_first) && (icur <= meta.i_last))
    else $error("column index left its burst range");

  a_jcur_range: assert property (@(posedge clk) disable iff (rst)
    (bvalid && meta.has_out) |-> (jcur >= meta.j_first) && (jcur <= meta.j_last))
    else $error("row index left its burst range");

  a_frame_ends_run: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.frame_last) |-> res.run_last)
    else $error("frame end not at end of burst");

endmodule

// ===== rtl/bblur_out.sv =====
// Divide-by-25 and output skid buffer for the result stream.
// Depends on bblur_pkg.
module bblur_out (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  res_valid,
  input  bblur_pkg::res_t                       res,
  output logic                                  adv,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [bblur_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  output logic                                  m_axis_tlast,
  output logic                                  m_axis_tuser
);
  import bblur_pkg::*;

  logic [PROD_BITS-1:0] prod_r;
  logic [PROD_BITS-1:0] prod_g;
  logic [PROD_BITS-1:0] prod_b;
  out_beat_t            beat;
  logic                 push;
  logic                 ovalid;
  out_beat_t            odata;
  logic                 skid_valid;
  out_beat_t            sdata;

  // sum / 25 exact for sums below 43690
  always_comb begin
    prod_r          = PROD_BITS'(res.sum.red)   * PROD_BITS'(DIV_MULT);
    prod_g          = PROD_BITS'(res.sum.green) * PROD_BITS'(DIV_MULT);
    prod_b          = PROD_BITS'(res.sum.blue)  * PROD_BITS'(DIV_MULT);
    beat.rgb.red    = prod_r[DIV_SHIFT +: CH_BITS];
    beat.rgb.green  = prod_g[DIV_SHIFT +: CH_BITS];
    beat.rgb.blue   = prod_b[DIV_SHIFT +: CH_BITS];
    beat.row        = res.row;
    beat.col        = res.col;
    beat.run_last   = res.run_last;
    beat.frame_last = res.frame_last;
  end

  assign adv  = !skid_valid;
  assign push = res_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid     <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!ovalid || m_axis_tready) begin
      if (skid_valid) begin
        ovalid     <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        ovalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ovalid || m_axis_tready) begin
      if (skid_valid) begin
        odata <= sdata;
      end else if (push) begin
        odata <= beat;
      end
    end else if (push) begin
      sdata <= beat;
    end
  end

  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = OUT_DATA_BITS'({odata.col, odata.row, odata.rgb});
  assign m_axis_tlast  = odata.run_last;
  assign m_axis_tuser  = odata.frame_last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> ovalid)
    else $error("skid holds a beat while output is empty");

endmodule

// ===== rtl/rgb_box_blur_5x5.sv =====
// 5x5 zero-padded RGB box blur, top level.
// Path: input register, line cells, window taps, result register, output register.
// Throughput: one pixel per clock unless the output stalls or a burst holds input;
//   bursts: 3 results at a row end, 3 per last-row pixel, 9 for the final pixel.
// Reset: counters to row 0 column 0, size 1024x1024, pipeline emptied; line store
//   contents are not cleared (no clearing pass); stale rows are masked until written.
// Depends on bblur_pkg, bblur_line_cell, bblur_window, bblur_out.
module rgb_box_blur_5x5 (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration: index 0 image_width, 1 image_height
  input  logic                                   cfg_we,
  input  logic [bblur_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [bblur_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  // pixel stream in
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [bblur_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,   // red_in, green_in, blue_in
  // result stream out
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [bblur_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,   // red_out, green_out,
                                                                 // blue_out, out_row, out_col
  output logic                                   m_axis_tlast,   // run_last
  output logic                                   m_axis_tuser    // frame_last
);
  import bblur_pkg::*;

  // position of the next pixel and the effective last row / column
  logic [ROW_BITS-1:0]  row_counter;
  logic [COL_BITS-1:0]  col_counter;
  logic [COL_BITS-1:0]  wlast;
  logic [ROW_BITS-1:0]  hlast;
  logic [COL_BITS-1:0]  wlast_next;
  logic [ROW_BITS-1:0]  hlast_next;
  logic [WCFG_BITS-1:0] wcfg;
  logic [HCFG_BITS-1:0] hcfg;

  logic       front_en;
  logic       in_xfer;
  logic       has_rows;
  logic       has_cols;
  item_meta_t s0_meta_next;

  // input register stage
  logic       s0_valid;
  item_meta_t s0_meta;
  pixel_t     s0_pix;

  cell_bus_t          chain_bus [LINE_CELLS+1];
  logic [LINE_CELLS:0] chain_valid;

  logic adv;
  logic res_valid;
  res_t res;

  assign s_axis_tready = front_en;
  assign in_xfer       = s_axis_tvalid && front_en;

  // size registers hold last index; 0 acts as 1, oversize clamps to the maximum
  always_comb begin
    wcfg = cfg_data[WCFG_BITS-1:0];
    hcfg = cfg_data[HCFG_BITS-1:0];
    if (wcfg == '0) begin
      wlast_next = '0;
    end else if (wcfg > WCFG_BITS'(MAX_WIDTH)) begin
      wlast_next = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      wlast_next = COL_BITS'(wcfg - 1'b1);
    end
    if (hcfg == '0) begin
      hlast_next = '0;
    end else if (hcfg > HCFG_BITS'(MAX_HEIGHT)) begin
      hlast_next = ROW_BITS'(MAX_HEIGHT - 1);
    end else begin
      hlast_next = ROW_BITS'(hcfg - 1'b1);
    end
  end

  // any write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      col_counter <= '0;
      wlast       <= COL_BITS'(WIDTH_RESET - 1);
      hlast       <= ROW_BITS'(HEIGHT_RESET - 1);
    end else if (cfg_we) begin
      row_counter <= '0;
      col_counter <= '0;
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  wlast <= wlast_next;
        REG_IMAGE_HEIGHT: hlast <= hlast_next;
        default: ;
      endcase
    end else if (in_xfer) begin
      if (col_counter == wlast) begin
        col_counter <= '0;
        row_counter <= (row_counter == hlast) ? '0 : row_counter + 1'b1;
      end else begin
        col_counter <= col_counter + 1'b1;
      end
    end
  end

  // Which centers this pixel finishes. Mid-frame only the center two rows up
  // and two columns left; the last row adds the centers below it, the last
  // column the ones to its right. Near the top/left edge the list starts later.
  always_comb begin
    s0_meta_next          = '0;
    s0_meta_next.row      = row_counter;
    s0_meta_next.col      = col_counter;
    s0_meta_next.last_row = (row_counter == hlast);
    s0_meta_next.last_col = (col_counter == wlast);
    for (int k = 0; k < WIN; k++) begin
      s0_meta_next.rmask[k] = (row_counter >= ROW_BITS'(k));
      s0_meta_next.cmask[k] = (col_counter >= COL_BITS'(k));
    end
    if (s0_meta_next.last_row) begin
      has_rows             = 1'b1;
      s0_meta_next.j_first = (row_counter >= ROW_BITS'(WIN_LO)) ? 2'd0 :
                             sel_t'(WIN_LO) - row_counter[1:0];
      s0_meta_next.j_last  = sel_t'(WIN_LO);
    end else begin
      has_rows             = (row_counter >= ROW_BITS'(WIN_LO));
      s0_meta_next.j_first = 2'd0;
      s0_meta_next.j_last  = 2'd0;
    end
    if (s0_meta_next.last_col) begin
      has_cols             = 1'b1;
      s0_meta_next.i_first = (col_counter >= COL_BITS'(WIN_LO)) ? 2'd0 :
                             sel_t'(WIN_LO) - col_counter[1:0];
      s0_meta_next.i_last  = sel_t'(WIN_LO);
    end else begin
      has_cols             = (col_counter >= COL_BITS'(WIN_LO));
      s0_meta_next.i_first = 2'd0;
      s0_meta_next.i_last  = 2'd0;
    end
    s0_meta_next.has_out = has_rows && has_cols;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (front_en) begin
      s0_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      s0_meta <= s0_meta_next;
      s0_pix  <= pixel_t'(s_axis_tdata[PIX_BITS-1:0]);
    end
  end

  // column sum starts empty at the head of the chain
  always_comb begin
    chain_bus[0].meta     = s0_meta;
    chain_bus[0].pix      = s0_pix;
    chain_bus[0].acc      = '0;
    chain_bus[0].acc_prev = '0;
  end
  assign chain_valid[0] = s0_valid;

  // four line cells; cell k holds the row k+1 above and passes it down
  for (genvar g = 0; g < LINE_CELLS; g++) begin : g_cell
    bblur_line_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (front_en),
      .in_valid  (chain_valid[g]),
      .in_bus    (chain_bus[g]),
      .out_valid (chain_valid[g+1]),
      .out_bus   (chain_bus[g+1])
    );
  end

  // sliding 5-column window and burst sequencer; it paces the whole front
  bblur_window u_window (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (chain_valid[LINE_CELLS]),
    .in_bus    (chain_bus[LINE_CELLS]),
    .take      (front_en),
    .res_valid (res_valid),
    .res       (res)
  );

  // divide and skid; adv drops only while the skid entry is full
  bblur_out u_out (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res           (res),
    .adv           (adv),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_counters_in_frame: assert property (@(posedge clk) disable iff (rst)
    (col_counter <= wlast) && (row_counter <= hlast))
    else $error("pixel position outside the frame");

  a_xfer_enters_stage: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !cfg_we) |=> s0_valid)
    else $error("accepted pixel lost at input stage");

endmodule
